FILE: rtl/core/ncl_pkg.sv
// Shared widths, token kind codes and the result item type for the number and comment lexer.
package ncl_pkg;

  // Position counter width default and the fixed width of reported positions
  localparam int POS_WIDTH_DEF = 16;
  localparam int OUT_POS_W     = 16;
  localparam int KIND_W        = 2;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EOF     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INT     = 2'd2;

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0]    token_kind;
    logic [OUT_POS_W-1:0] token_start;
    logic [OUT_POS_W-1:0] token_end;
    logic                 last_of_run;
  } token_t;

endpackage

FILE: rtl/core/ncl_if.sv
// Handshake interfaces for the source byte channel and the token channel.
interface ncl_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       buffer_end;

  modport source (output valid, output text_byte, output buffer_end, input ready);
  modport sink   (input valid, input text_byte, input buffer_end, output ready);
endinterface

interface ncl_token_if;
  logic                                valid;
  logic                                ready;
  logic [ncl_pkg::KIND_W-1:0]          token_kind;
  logic [ncl_pkg::OUT_POS_W-1:0]       token_start;
  logic [ncl_pkg::OUT_POS_W-1:0]       token_end;
  logic                                last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_end,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start, input token_end,
                  input last_of_run, output ready);
endinterface

FILE: rtl/core/number_comment_lexer_top.sv
// Top level of the number and comment lexer.
//
//   channel  role   payload
//   text     sink   text_byte[7:0], buffer_end
//   tokens   source token_kind[1:0], token_start[15:0], token_end[15:0], last_of_run
//
// One source byte is taken per cycle; it is registered, decoded against the lexer
// state in that next cycle, and any token lands in a two-entry result buffer.
// An end item that flushes a pending token gives two results, the flushed token
// and then the EOF token, and the input is held off until both are pushed.
// Otherwise the input stalls only when the result buffer is full.
// rst (synchronous) returns the lexer to the start state with positions at zero
// and empties the result buffer.
module number_comment_lexer_top #(
  parameter int POS_WIDTH = ncl_pkg::POS_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  ncl_text_if.sink    text,
  ncl_token_if.source tokens
);

  logic            room;
  logic            push;
  ncl_pkg::token_t push_tok;
  ncl_pkg::token_t head;

  // Lexer stage
  ncl_lex #(
    .POS_WIDTH (POS_WIDTH)
  ) u_lex (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text.valid),
    .text_ready (text.ready),
    .text_byte  (text.text_byte),
    .buffer_end (text.buffer_end),
    .room       (room),
    .push       (push),
    .token      (push_tok)
  );

  // Result buffer
  ncl_out_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .token (push_tok),
    .room  (room),
    .valid (tokens.valid),
    .ready (tokens.ready),
    .head  (head)
  );

  assign tokens.token_kind  = head.token_kind;
  assign tokens.token_start = head.token_start;
  assign tokens.token_end   = head.token_end;
  assign tokens.last_of_run = head.last_of_run;

  // An end-of-file token always closes its run
  a_eof_last : assert property (@(posedge clk) disable iff (rst)
    push && (push_tok.token_kind == ncl_pkg::KIND_EOF) |-> push_tok.last_of_run)
    else $error("EOF token not marked last");

  // An end-of-file token is empty
  a_eof_empty : assert property (@(posedge clk) disable iff (rst)
    push && (push_tok.token_kind == ncl_pkg::KIND_EOF) |->
      (push_tok.token_start == push_tok.token_end))
    else $error("EOF token not empty");

  // A token that does not close its run is a flushed literal or invalid run
  a_first_kind : assert property (@(posedge clk) disable iff (rst)
    push && !push_tok.last_of_run |->
      ((push_tok.token_kind == ncl_pkg::KIND_INT) ||
       (push_tok.token_kind == ncl_pkg::KIND_INVALID)))
    else $error("non-final token of wrong kind");

  // Reset empties the result buffer
  a_rst_empty : assert property (@(posedge clk) rst |=> !tokens.valid)
    else $error("result buffer not empty after reset");

endmodule

FILE: rtl/core/ncl_lex.sv
// Lexer stage: input item register, lexer state and next-state / token logic.
module ncl_lex #(
  parameter int POS_WIDTH = ncl_pkg::POS_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            text_valid,
  output logic            text_ready,
  input  logic [7:0]      text_byte,
  input  logic            buffer_end,
  input  logic            room,
  output logic            push,
  output ncl_pkg::token_t token
);

  // Lexer modes
  localparam logic [2:0] MODE_START   = 3'd0;
  localparam logic [2:0] MODE_INT     = 3'd1;
  localparam logic [2:0] MODE_COMMENT = 3'd2;
  localparam logic [2:0] MODE_CR      = 3'd3;
  localparam logic [2:0] MODE_INVALID = 3'd4;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Held input item
  logic                 hold_valid;
  logic [7:0]           hold_byte;
  logic                 hold_end;
  // Flush token of an end item already sent, EOF still to go
  logic                 phase;

  // Lexer state
  logic [2:0]           mode;
  logic [POS_WIDTH-1:0] pos;
  logic [POS_WIDTH-1:0] org;

  logic [2:0]           mode_next;
  logic [POS_WIDTH-1:0] org_next;
  logic [POS_WIDTH-1:0] pos_inc;
  logic [2:0]           sb_mode;
  logic [POS_WIDTH-1:0] sb_org;

  logic is_ws, is_lf, is_cr, is_hash, is_digit, is_nul;
  logic emit_byte;
  logic [ncl_pkg::KIND_W-1:0] flush_kind;
  logic has_flush;
  logic step;
  logic done;
  logic drain;

  // Byte classes
  always_comb begin
    is_lf    = (hold_byte == CH_LF);
    is_cr    = (hold_byte == CH_CR);
    is_ws    = (hold_byte == CH_SPACE) || (hold_byte == CH_TAB) || is_cr || is_lf;
    is_hash  = (hold_byte == CH_HASH);
    is_digit = (hold_byte >= CH_ZERO) && (hold_byte <= CH_NINE);
    is_nul   = (hold_byte == CH_NUL);
  end

  // Saturating position increment
  assign pos_inc = (&pos) ? pos : pos + 1'b1;

  // What the start state does with this byte
  always_comb begin
    if (is_ws) begin
      sb_mode = MODE_START;
      sb_org  = pos_inc;
    end else begin
      sb_org = pos;
      if (is_hash)       sb_mode = MODE_COMMENT;
      else if (is_digit) sb_mode = MODE_INT;
      else               sb_mode = MODE_INVALID;
    end
  end

  // Next mode and token origin for an ordinary byte
  always_comb begin
    mode_next = sb_mode;
    org_next  = sb_org;
    emit_byte = 1'b0;
    case (mode)
      MODE_INT: begin
        if (is_digit) begin
          mode_next = MODE_INT;
          org_next  = org;
        end else begin
          emit_byte = 1'b1;
        end
      end
      MODE_COMMENT: begin
        org_next = org;
        if (is_lf) begin
          mode_next = MODE_START;
          org_next  = pos_inc;
        end else if (is_cr) begin
          mode_next = MODE_CR;
        end else if (is_nul) begin
          mode_next = MODE_INVALID;
        end else begin
          mode_next = MODE_COMMENT;
        end
      end
      MODE_CR: begin
        if (is_lf) begin
          mode_next = MODE_START;
          org_next  = pos_inc;
        end else begin
          mode_next = MODE_INVALID;
          org_next  = org;
        end
      end
      MODE_INVALID: begin
        if (is_lf) begin
          emit_byte = 1'b1;
        end else begin
          mode_next = MODE_INVALID;
          org_next  = org;
        end
      end
      default: begin
        mode_next = sb_mode;
        org_next  = sb_org;
      end
    endcase
  end

  // Pending token flushed by an end item
  always_comb begin
    has_flush  = (mode == MODE_INT) || (mode == MODE_CR) || (mode == MODE_INVALID);
    flush_kind = (mode == MODE_INT) ? ncl_pkg::KIND_INT : ncl_pkg::KIND_INVALID;
  end

  // Result item and handshake
  always_comb begin
    token.token_start = ncl_pkg::OUT_POS_W'(org);
    token.token_end   = ncl_pkg::OUT_POS_W'(pos);
    token.last_of_run = 1'b1;
    token.token_kind  = (mode == MODE_INT) ? ncl_pkg::KIND_INT : ncl_pkg::KIND_INVALID;
    step = hold_valid && room;
    done = 1'b1;
    push = 1'b0;
    if (hold_end) begin
      push = step;
      if (has_flush && !phase) begin
        token.token_kind  = flush_kind;
        token.last_of_run = 1'b0;
        done              = 1'b0;
      end else begin
        token.token_kind  = ncl_pkg::KIND_EOF;
        token.token_start = ncl_pkg::OUT_POS_W'(pos);
      end
    end else begin
      push = step && emit_byte;
    end
    drain      = step && done;
    text_ready = !hold_valid || drain;
  end

  // Input item register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (text_ready) begin
      hold_valid <= text_valid;
    end
    if (text_valid && text_ready) begin
      hold_byte <= text_byte;
      hold_end  <= buffer_end;
    end
  end

  // Lexer state update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_START;
      pos   <= '0;
      org   <= '0;
      phase <= 1'b0;
    end else if (drain) begin
      phase <= 1'b0;
      if (hold_end) begin
        mode <= MODE_START;
        pos  <= '0;
        org  <= '0;
      end else begin
        mode <= mode_next;
        pos  <= pos_inc;
        org  <= org_next;
      end
    end else if (step) begin
      phase <= 1'b1;
    end
  end

endmodule

FILE: rtl/core/ncl_out_fifo.sv
// Two-entry result buffer between the lexer stage and the token channel.
module ncl_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ncl_pkg::token_t token,
  output logic            room,
  output logic            valid,
  input  logic            ready,
  output ncl_pkg::token_t head
);

  localparam int DEPTH = 2;

  ncl_pkg::token_t      entry [DEPTH];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 pop;

  assign room  = (count < 2'(DEPTH));
  assign valid = (count != 2'd0);
  assign pop   = valid && ready;
  assign head  = entry[rd_ptr];

  // Storage write
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= token;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: tb/number_comment_lexer_top_tb.sv
// Self-checking testbench for the number and comment lexer top level.
`timescale 1ns / 100ps

module number_comment_lexer_top_tb;

  // Source bytes the lexer treats specially
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [15:0] POS_SAT      = 16'hFFFF;
  localparam int          RANDOM_ITEMS = 1000;
  localparam int          QUIET_ITEMS  = 150;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          LONG_BUFFER  = 120;
  localparam int          DRAIN_LIMIT  = 5000;
  localparam int          RUN_LIMIT_NS = 8_000_000;

  typedef enum logic [2:0] {
    LX_START   = 3'd0,
    LX_INT     = 3'd1,
    LX_COMMENT = 3'd2,
    LX_CR      = 3'd3,
    LX_INVALID = 3'd4
  } lex_mode_e;

  // Lexer predictor and store of tokens still to arrive
  class token_scoreboard;
    lex_mode_e       mode;
    logic [15:0]     pos;
    logic [15:0]     origin;
    ncl_pkg::token_t expected_q[$];
    int              errors;
    int              items;
    int              buffers;
    int              saturated;
    int              kind_count[3];

    function new();
      reset_lexer();
      errors    = 0;
      items     = 0;
      buffers   = 0;
      saturated = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
    endfunction

    function void reset_lexer();
      mode   = LX_START;
      pos    = '0;
      origin = '0;
    endfunction

    function void advance();
      if (pos != POS_SAT) pos++;
      else saturated++;
    endfunction

    function void add_token(logic [ncl_pkg::KIND_W-1:0] kind, logic [15:0] first,
                            logic [15:0] past);
      ncl_pkg::token_t t;
      t.token_kind  = kind;
      t.token_start = first;
      t.token_end   = past;
      t.last_of_run = 1'b0;
      expected_q.push_back(t);
    endfunction

    // Start state: blanks are skipped, anything else opens a token
    function void start_byte(logic [7:0] b);
      if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
        advance();
        origin = pos;
        mode   = LX_START;
      end else begin
        origin = pos;
        advance();
        if (b == CH_HASH) mode = LX_COMMENT;
        else if (b >= CH_ZERO && b <= CH_NINE) mode = LX_INT;
        else mode = LX_INVALID;
      end
    endfunction

    // Called once per accepted input item
    function void note_item(logic [7:0] b, logic fin);
      int queued;
      queued = expected_q.size();
      items++;
      if (fin) begin
        // flush any pending token, then end of file, then back to reset state
        if (mode == LX_INT) add_token(ncl_pkg::KIND_INT, origin, pos);
        else if (mode == LX_CR || mode == LX_INVALID)
          add_token(ncl_pkg::KIND_INVALID, origin, pos);
        add_token(ncl_pkg::KIND_EOF, pos, pos);
        reset_lexer();
        buffers++;
      end else begin
        case (mode)
          LX_INT: begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
              advance();
            end else begin
              add_token(ncl_pkg::KIND_INT, origin, pos);
              start_byte(b);
            end
          end
          LX_COMMENT: begin
            advance();
            if (b == CH_LF) begin
              origin = pos;
              mode   = LX_START;
            end else if (b == CH_CR) begin
              mode = LX_CR;
            end else if (b == CH_NUL) begin
              mode = LX_INVALID;
            end
          end
          LX_CR: begin
            advance();
            if (b == CH_LF) begin
              origin = pos;
              mode   = LX_START;
            end else begin
              mode = LX_INVALID;
            end
          end
          LX_INVALID: begin
            if (b == CH_LF) begin
              add_token(ncl_pkg::KIND_INVALID, origin, pos);
              start_byte(b);
            end else begin
              advance();
            end
          end
          default: start_byte(b);
        endcase
      end
      if (expected_q.size() > queued) expected_q[expected_q.size()-1].last_of_run = 1'b1;
    endfunction

    // Compare one accepted token with the oldest expectation
    function void check_token(ncl_pkg::token_t got);
      ncl_pkg::token_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: token with none expected, actual kind %0d start %0d end %0d last %0b",
                 $time, got.token_kind, got.token_start, got.token_end, got.last_of_run);
        return;
      end
      want = expected_q.pop_front();
      kind_count[want.token_kind]++;
      if (got.token_kind !== want.token_kind) begin
        errors++;
        $display("%0t: token_kind expected %0d actual %0d",
                 $time, want.token_kind, got.token_kind);
      end
      if (got.token_start !== want.token_start) begin
        errors++;
        $display("%0t: token_start expected %0d actual %0d",
                 $time, want.token_start, got.token_start);
      end
      if (got.token_end !== want.token_end) begin
        errors++;
        $display("%0t: token_end expected %0d actual %0d",
                 $time, want.token_end, got.token_end);
      end
      if (got.last_of_run !== want.last_of_run) begin
        errors++;
        $display("%0t: last_of_run expected %0b actual %0b",
                 $time, want.last_of_run, got.last_of_run);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void close_out();
      if (expected_q.size() != 0) begin
        errors++;
        $display("%0t: %0d tokens never arrived, oldest expected kind %0d start %0d end %0d",
                 $time, expected_q.size(), expected_q[0].token_kind,
                 expected_q[0].token_start, expected_q[0].token_end);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  ncl_text_if  text ();
  ncl_token_if tokens ();

  number_comment_lexer_top dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .tokens (tokens)
  );

  token_scoreboard sb = new();

  bit         idle_on    = 1'b1;
  int         hold_asked = 0;
  int         hold_given = 0;
  logic [7:0] text_q[$];

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Token sink: checks accepted items, stalls in bursts and on request
  initial begin : token_sink
    int              stall_left;
    int              hold_left;
    ncl_pkg::token_t got;
    stall_left = 0;
    hold_left  = 0;
    tokens.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tokens.valid === 1'b1 && tokens.ready === 1'b1) begin
        got = '{tokens.token_kind, tokens.token_start, tokens.token_end, tokens.last_of_run};
        sb.check_token(got);
      end
      if (hold_given < hold_asked) begin
        hold_given++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        tokens.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        tokens.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        tokens.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        tokens.ready <= 1'b1;
      end
    end
  end

  // Offer one item, with an optional idle burst first, and wait for it to be taken
  task automatic send_item(input logic [7:0] b, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      text.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    text.valid      <= 1'b1;
    text.text_byte  <= b;
    text.buffer_end <= fin;
    do @(posedge clk); while (text.ready !== 1'b1);
    sb.note_item(b, fin);
  endtask

  // Send the queued bytes as one buffer and close it with an end item
  task automatic send_buffer();
    for (int i = 0; i < text_q.size(); i++) send_item(text_q[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    text_q.delete();
  endtask

  task automatic wait_for_tokens();
    text.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] comment_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_LF || c == CH_CR);
    return c;
  endfunction

  // Append one well-formed token (or a stray byte) to the buffer under construction
  function automatic void append_token();
    int         n;
    logic [7:0] c;
    case ($urandom_range(0, 6))
      0: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: text_q.push_back(CH_SPACE);
            1: text_q.push_back(CH_TAB);
            2: text_q.push_back(CH_CR);
            default: text_q.push_back(CH_LF);
          endcase
        end
      end
      1: begin
        n = $urandom_range(1, 5);
        repeat (n) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      2: begin
        text_q.push_back(CH_HASH);
        n = $urandom_range(0, 6);
        repeat (n) text_q.push_back(comment_byte());
        n = $urandom_range(0, 19);
        if (n < 14) begin
          text_q.push_back(CH_LF);
        end else if (n < 17) begin
          text_q.push_back(CH_CR);
          text_q.push_back(CH_LF);
        end
      end
      3: begin
        // invalid run: opening byte that cannot start anything else
        do c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_HASH ||
               (c >= CH_ZERO && c <= CH_NINE));
        text_q.push_back(c);
        n = $urandom_range(0, 4);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
          text_q.push_back(c);
        end
        if ($urandom_range(0, 3) != 0) text_q.push_back(CH_LF);
      end
      4: begin
        // comment whose CR is or is not followed by LF
        text_q.push_back(CH_HASH);
        n = $urandom_range(0, 3);
        repeat (n) text_q.push_back(comment_byte());
        text_q.push_back(CH_CR);
        text_q.push_back($urandom_range(0, 1) ? CH_LF : 8'($urandom_range(0, 255)));
      end
      5: text_q.push_back(CH_NUL);
      default: text_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  // Stimulus
  initial begin : stimulus
    int random_items;
    int n;
    int spins;
    random_items = 0;
    rst             <= 1'b1;
    text.valid      <= 1'b0;
    text.text_byte  <= '0;
    text.buffer_end <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty buffer gives end of file alone
    send_item(CH_NUL, 1'b1);
    // digits ended by blank, then the other blanks
    send_item(CH_ZERO, 1'b0);
    send_item(CH_NINE, 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    // comment closed by CR LF
    send_item(CH_HASH, 1'b0);
    send_item("a", 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    // bad byte after comment CR turns it into an invalid run
    send_item(CH_HASH, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item("a", 1'b0);
    send_item(CH_LF, 1'b0);
    // zero byte and top byte as an invalid run flushed at the end
    send_item(CH_NUL, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    // zero byte inside a comment
    send_item(CH_HASH, 1'b0);
    send_item(CH_NUL, 1'b0);
    send_item(CH_LF, 1'b0);
    // comment ending in CR at the end of the buffer
    send_item(CH_HASH, 1'b0);
    send_item(CH_CR, 1'b0);
    send_item(CH_NUL, 1'b1);
    // literal flushed by the end item
    send_item(CH_ZERO + 8'd5, 1'b0);
    send_item(CH_NUL, 1'b1);
    wait_for_tokens();

    // One longer buffer of mixed tokens
    while (text_q.size() < LONG_BUFFER) append_token();
    send_buffer();

    // Sink held off while one-digit literals keep coming, so the input backs up
    hold_asked++;
    for (int i = 0; i < 40; i++) begin
      send_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      send_item(CH_SPACE, 1'b0);
    end
    send_item(CH_NUL, 1'b1);
    wait_for_tokens();

    // Random buffers, mostly well formed, some pure noise; no idling at the tail
    while (random_items < RANDOM_ITEMS) begin
      idle_on = (random_items < RANDOM_ITEMS - QUIET_ITEMS);
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(0, 20);
        repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(0, 6);
        repeat (n) append_token();
      end
      random_items += text_q.size() + 1;
      send_buffer();
    end

    // Drain, then allow for the pipeline to settle
    text.valid <= 1'b0;
    spins = 0;
    while (sb.pending() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (16) @(posedge clk);
    sb.close_out();

    $display("Run covered %0d buffers and %0d input items, %0d integer, %0d invalid, %0d EOF tokens.",
             sb.buffers, sb.items, sb.kind_count[ncl_pkg::KIND_INT],
             sb.kind_count[ncl_pkg::KIND_INVALID], sb.kind_count[ncl_pkg::KIND_EOF]);
    $display("Position counter sat at its maximum for %0d bytes; sink held off %0d time(s).",
             sb.saturated, hold_given);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
